FILE: hw/rtl/radial_stick_dead_zone_defines.svh
// Assertion macros for the radial stick dead zone block.
// Used by the RTL files that carry concurrent checks; no other dependencies.
`ifndef RADIAL_STICK_DEAD_ZONE_DEFINES_SVH
`define RADIAL_STICK_DEAD_ZONE_DEFINES_SVH
`ifndef SYNTHESIS
`define RSDZ_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define RSDZ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define RSDZ_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define RSDZ_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: hw/rtl/rsdz_pkg.sv
// Shared types and constants for the radial stick dead zone block.
// No dependencies.
`timescale 1ns / 1ps
package rsdz_pkg;
  localparam int AXIS_WIDTH = 16;
  localparam int OUT_W      = 16;
  localparam int RAD_W      = 16;
  localparam int SQ_W       = 2 * RAD_W;
  localparam int REM_W      = RAD_W + 2;
  localparam int SQRT_STEPS = SQ_W / 2;
  localparam int Q_W        = 15;
  localparam int DVS_W      = 2 * RAD_W;
  localparam int NUM_W      = DVS_W + Q_W;
  localparam int ADDR_W     = 3;
  localparam int DATA_W     = 32;

  localparam int ST_SQ      = 1;
  localparam int ST_SUM     = 2;
  localparam int ST_RT0     = 3;
  localparam int ST_PA      = ST_RT0 + SQRT_STEPS;
  localparam int ST_PB      = ST_PA + 1;
  localparam int ST_PC      = ST_PB + 1;
  localparam int ST_DIV0    = ST_PC + 1;
  localparam int ST_OUT     = ST_DIV0 + Q_W;
  localparam int NUM_STAGES = ST_OUT + 1;

  localparam logic [RAD_W-1:0] DZ_RESET = 16'd8000;
  localparam logic [RAD_W-1:0] FS_RESET = 16'd30000;

  typedef enum logic {
    REG_DEAD_ZONE  = 1'b0,
    REG_FULL_SCALE = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic neg_x;
    logic neg_y;
    logic dead;
    logic zero;
  } rsdz_side_t;
endpackage

FILE: hw/rtl/radial_stick_dead_zone.sv
// Radial dead zone for one stick sample: one word in and one word out per cycle while the
// output is not stalled. The pipeline is the 16-stage square root pipeline and the
// 15-stage restoring divider, plus seven stages for magnitude, squares, sum, ramp,
// products and output. A stall freezes the whole pipeline.
// Depends on rsdz_pkg, rsdz_div and radial_stick_dead_zone_defines.svh.
`timescale 1ns / 1ps
`include "radial_stick_dead_zone_defines.svh"
module radial_stick_dead_zone
  import rsdz_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ADDR_W-1:0]            paddr,
  input  logic [DATA_W-1:0]            pwdata,
  output logic [DATA_W-1:0]            prdata,
  output logic                         pready,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [AXIS_WIDTH-1:0] axis_x_i,
  input  logic signed [AXIS_WIDTH-1:0] axis_y_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [OUT_W-1:0]      scaled_x_o,
  output logic signed [OUT_W-1:0]      scaled_y_o,
  output logic                         in_dead_zone_o
);
  logic [RAD_W-1:0]      dz_q, fs_q;
  logic [SQ_W-1:0]       dzsq_q;
  logic                  en;
  logic [NUM_STAGES-1:0] vld_q;
  rsdz_side_t            side_q [NUM_STAGES];
  logic [RAD_W-1:0]      mag_x_q [ST_PA+1];
  logic [RAD_W-1:0]      mag_y_q [ST_PA+1];
  logic [RAD_W-1:0]      ax, ay;
  logic [SQ_W-1:0]       sq_x_q, sq_y_q, sum_d, sum_q;
  logic [REM_W-1:0]      rem_q  [SQRT_STEPS];
  logic [RAD_W-1:0]      root_q [SQRT_STEPS];
  logic [SQ_W-1:0]       rad_q  [SQRT_STEPS];
  logic [RAD_W-1:0]      len_q, num_q, den_q, diff, span, num_d, den_d;
  logic                  ramp;
  logic [DVS_W-1:0]      dvs_q, px_q, py_q, dvs_c_q;
  logic [NUM_W-1:0]      nx_q, ny_q;
  logic [Q_W-1:0]        qx, qy;
  logic [OUT_W-1:0]      sx_q, sy_q;
  logic                  force_zero;

  // config port
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dz_q <= DZ_RESET;
      fs_q <= FS_RESET;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_DEAD_ZONE:  dz_q <= pwdata[RAD_W-1:0];
        REG_FULL_SCALE: fs_q <= pwdata[RAD_W-1:0];
        default:        ;
      endcase
    end
  end
  always_comb begin
    case (paddr[2])
      REG_DEAD_ZONE:  prdata = DATA_W'(dz_q);
      REG_FULL_SCALE: prdata = DATA_W'(fs_q);
      default:        prdata = '0;
    endcase
  end
  always_ff @(posedge clk_i) dzsq_q <= dz_q * dz_q;

  // flow control
  assign en         = !(vld_q[NUM_STAGES-1] && out_stall_i);
  assign in_stall_o = !en;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (en) vld_q <= {vld_q[NUM_STAGES-2:0], in_valid_i};
  end

  assign ax    = axis_x_i[AXIS_WIDTH-1] ? RAD_W'(-axis_x_i) : RAD_W'(axis_x_i);
  assign ay    = axis_y_i[AXIS_WIDTH-1] ? RAD_W'(-axis_y_i) : RAD_W'(axis_y_i);
  assign sum_d = sq_x_q + sq_y_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      mag_x_q[0] <= ax;
      mag_y_q[0] <= ay;
      for (int k = 1; k <= ST_PA; k++) begin
        mag_x_q[k] <= mag_x_q[k-1];
        mag_y_q[k] <= mag_y_q[k-1];
      end
      side_q[0] <= '{neg_x: axis_x_i[AXIS_WIDTH-1], neg_y: axis_y_i[AXIS_WIDTH-1],
                     dead: 1'b0, zero: 1'b0};
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (k != ST_SUM && k != ST_PA) side_q[k] <= side_q[k-1];
      end
      side_q[ST_SUM] <= '{neg_x: side_q[ST_SUM-1].neg_x, neg_y: side_q[ST_SUM-1].neg_y,
                          dead: sum_d < dzsq_q, zero: side_q[ST_SUM-1].zero};
      side_q[ST_PA]  <= '{neg_x: side_q[ST_PA-1].neg_x, neg_y: side_q[ST_PA-1].neg_y,
                          dead: side_q[ST_PA-1].dead,
                          zero: root_q[SQRT_STEPS-1] == '0};
      sq_x_q <= mag_x_q[0] * mag_x_q[0];
      sq_y_q <= mag_y_q[0] * mag_y_q[0];
      sum_q  <= sum_d;
    end
  end

  // square root, two bits of the radicand per stage
  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    localparam int BH = SQ_W - 1 - 2 * k;
    logic [REM_W-1:0] rem_in;
    logic [RAD_W-1:0] root_in;
    logic [SQ_W-1:0]  rad_in;
    logic [REM_W+1:0] cur, trial;
    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = sum_q;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign rad_in  = rad_q[k-1];
    end
    assign cur   = {rem_in, rad_in[BH -: 2]};
    assign trial = (REM_W+2)'({root_in, 2'b01});
    always_ff @(posedge clk_i) begin
      if (en) begin
        rad_q[k] <= rad_in;
        if (cur >= trial) begin
          rem_q[k]  <= REM_W'(cur - trial);
          root_q[k] <= {root_in[RAD_W-2:0], 1'b1};
        end else begin
          rem_q[k]  <= REM_W'(cur);
          root_q[k] <= {root_in[RAD_W-2:0], 1'b0};
        end
      end
    end
  end

  // ramp
  assign ramp  = fs_q > dz_q;
  assign diff  = root_q[SQRT_STEPS-1] - dz_q;
  assign span  = fs_q - dz_q;
  assign num_d = ramp ? ((diff > span) ? span : diff) : RAD_W'(1);
  assign den_d = ramp ? span : RAD_W'(1);

  always_ff @(posedge clk_i) begin
    if (en) begin
      len_q   <= root_q[SQRT_STEPS-1];
      num_q   <= num_d;
      den_q   <= den_d;
      dvs_q   <= den_q * len_q;
      px_q    <= mag_x_q[ST_PA] * num_q;
      py_q    <= mag_y_q[ST_PA] * num_q;
      nx_q    <= (NUM_W'(px_q) << Q_W) - NUM_W'(px_q);
      ny_q    <= (NUM_W'(py_q) << Q_W) - NUM_W'(py_q);
      dvs_c_q <= dvs_q;
    end
  end

  rsdz_div u_div_x (
    .clk_i, .en_i(en), .dividend_i(nx_q), .divisor_i(dvs_c_q), .quot_o(qx)
  );
  rsdz_div u_div_y (
    .clk_i, .en_i(en), .dividend_i(ny_q), .divisor_i(dvs_c_q), .quot_o(qy)
  );

  assign force_zero = side_q[ST_OUT-1].dead || side_q[ST_OUT-1].zero;
  always_ff @(posedge clk_i) begin
    if (en) begin
      if (force_zero) sx_q <= '0;
      else if (side_q[ST_OUT-1].neg_x) sx_q <= OUT_W'(-{1'b0, qx});
      else sx_q <= {1'b0, qx};
      if (force_zero) sy_q <= '0;
      else if (side_q[ST_OUT-1].neg_y) sy_q <= OUT_W'(-{1'b0, qy});
      else sy_q <= {1'b0, qy};
    end
  end

  assign out_valid_o    = vld_q[NUM_STAGES-1];
  assign scaled_x_o     = sx_q;
  assign scaled_y_o     = sy_q;
  assign in_dead_zone_o = side_q[ST_OUT].dead;

  `RSDZ_ASSERT_IMPL(a_dead_zero, clk_i, rst_ni, out_valid_o && in_dead_zone_o, (sx_q | sy_q) == '0)
  `RSDZ_ASSERT_IMPL(a_no_min, clk_i, rst_ni, out_valid_o, !(sx_q[OUT_W-1] && sx_q[OUT_W-2:0] == '0))
  `RSDZ_ASSERT_NEXT(a_freeze, clk_i, rst_ni, !en, $stable(vld_q))
endmodule

FILE: hw/rtl/rsdz_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// Depends on rsdz_pkg.
`timescale 1ns / 1ps
module rsdz_div
  import rsdz_pkg::*;
(
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [NUM_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic [Q_W-1:0]   quot_o
);
  logic [NUM_W-1:0] rem_q [Q_W];
  logic [DVS_W-1:0] dvs_q [Q_W];
  logic [Q_W-1:0]   quo_q [Q_W];

  for (genvar j = 0; j < Q_W; j++) begin : g_stage
    logic [NUM_W-1:0] rem_in, trial, rem_d;
    logic [DVS_W-1:0] dvs_in;
    logic [Q_W-1:0]   quo_in, quo_d;
    if (j == 0) begin : g_first
      assign rem_in = dividend_i;
      assign dvs_in = divisor_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[j-1];
      assign dvs_in = dvs_q[j-1];
      assign quo_in = quo_q[j-1];
    end
    always_comb begin
      trial = NUM_W'(dvs_in) << (Q_W - 1 - j);
      if (rem_in >= trial) begin
        rem_d = rem_in - trial;
        quo_d = {quo_in[Q_W-2:0], 1'b1};
      end else begin
        rem_d = rem_in;
        quo_d = {quo_in[Q_W-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j] <= rem_d;
        dvs_q[j] <= dvs_in;
        quo_q[j] <= quo_d;
      end
    end
  end

  assign quot_o = quo_q[Q_W-1];
endmodule
